/* hdl/lprt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-prefix route table package
// Sizes, operation and status codes, and the types shared by the route table
// modules.
// ----------------------------------------------------------------------------
package lprt_pkg;

    // Number of route slots in the table.
    localparam int ROUTE_ENTRIES = 16;

    // Widths; ENTRY_W, COUNT_W and CMP_W are derived from the table size.
    localparam int ENTRY_W     = $clog2(ROUTE_ENTRIES);
    localparam int COUNT_W     = $clog2(ROUTE_ENTRIES + 1);
    localparam int IP_W        = 32;
    localparam int POS_W       = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int CMP_W       = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    // Operation codes.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROUTE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_POS  = 2'd3;

    // One stored route as it lies in the entry memory.
    typedef struct packed {
        logic [IP_W-1:0]    mask;
        logic [IP_W-1:0]    prefix;
        logic [IP_W-1:0]    hop;
        logic [ENTRY_W-1:0] rank;
    } route_entry_t;

    localparam int ENTRY_BITS = $bits(route_entry_t);

    // Control from the sequencer to the best-match tracker.
    typedef struct packed {
        logic clear;
        logic check;
        logic valid;
    } sel_ctrl_t;

    // Best candidate found so far in a lookup sweep.
    typedef struct packed {
        logic               found;
        logic [IP_W-1:0]    mask;
        logic [ENTRY_W-1:0] rank;
        logic [IP_W-1:0]    hop;
    } best_route_t;

endpackage

/* hdl/lprt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module lprt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lprt_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table best-match tracker
// Checks one entry per cycle against the destination and keeps the entry
// with the largest mask, the youngest one on equal masks.
// ----------------------------------------------------------------------------
module lprt_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lprt_pkg::sel_ctrl_t         ctrl,
    input  logic [lprt_pkg::IP_W-1:0]   ip,
    input  lprt_pkg::route_entry_t      entry,
    output lprt_pkg::best_route_t       best
);
    import lprt_pkg::*;

    logic               found_reg;
    logic               found_next;
    logic [IP_W-1:0]    mask_reg;
    logic [IP_W-1:0]    mask_next;
    logic [ENTRY_W-1:0] rank_reg;
    logic [ENTRY_W-1:0] rank_next;
    logic [IP_W-1:0]    hop_reg;
    logic [IP_W-1:0]    hop_next;
    logic               match;
    logic               better;

    // The entry matches when its masked destination equals its prefix.
    assign match = ctrl.valid && ((entry.mask & ip) == entry.prefix);

    // Larger mask wins; on equal masks the higher rank (younger) wins.
    assign better = !found_reg || (entry.mask > mask_reg) ||
                    ((entry.mask == mask_reg) && (entry.rank > rank_reg));

    // Next candidate.
    always_comb
    begin
        found_next = found_reg;
        mask_next  = mask_reg;
        rank_next  = rank_reg;
        hop_next   = hop_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.check && match && better)
        begin
            found_next = 1'b1;
            mask_next  = entry.mask;
            rank_next  = entry.rank;
            hop_next   = entry.hop;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // Candidate payload.
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        rank_reg <= rank_next;
        hop_reg  <= hop_next;
    end

    assign best.found = found_reg;
    assign best.mask  = mask_reg;
    assign best.rank  = rank_reg;
    assign best.hop   = hop_reg;

endmodule

/* hdl/longest_prefix_route_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-prefix route table
// Add, remove and lookup of IPv4 routes held in one entry memory, swept one
// entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Lookup and remove sweep the entry memory at one read per cycle, then pass
// through a tail and a finish state before done is raised.
// Add scans the valid bits for the lowest free slot.
// Full table, bad position and the unused opcode answer in the cycle after the transfer.
// busy is high while an operation runs; results cannot be stalled.
// Reset clears all valid bits and the entry count at once; no clearing pass.
module longest_prefix_route_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [1:0]                         opcode,
    input  logic [lprt_pkg::IP_W-1:0]          ip_addr,
    input  logic [lprt_pkg::IP_W-1:0]          mask,
    input  logic [lprt_pkg::IP_W-1:0]          next_hop,
    input  logic [lprt_pkg::POS_W-1:0]         position,
    output logic                               busy,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [lprt_pkg::IP_W-1:0]          hop_out,
    output logic                               direct,
    output logic [lprt_pkg::COUNT_OUT_W-1:0]   entry_count
);
    import lprt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [ENTRY_W-1:0] LAST_IDX = ENTRY_W'(ROUTE_ENTRIES - 1);

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [ENTRY_W-1:0]       cnt_reg;
    logic [ENTRY_W-1:0]       cnt_next;
    logic                     pend_reg;
    logic                     pend_next;
    logic [ENTRY_W-1:0]       pend_idx_reg;
    logic [ENTRY_W-1:0]       pend_idx_next;
    logic [ROUTE_ENTRIES-1:0] valid_reg;
    logic [ROUTE_ENTRIES-1:0] valid_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     done_reg;
    logic                     done_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [IP_W-1:0]          hop_out_reg;
    logic [IP_W-1:0]          hop_out_next;
    logic                     direct_reg;
    logic                     direct_next;

    // Operation payload held for the length of the operation.
    logic [1:0]               op_reg;
    logic [1:0]               op_next;
    logic [IP_W-1:0]          ip_reg;
    logic [IP_W-1:0]          ip_next;
    logic [IP_W-1:0]          mask_reg;
    logic [IP_W-1:0]          mask_next;
    logic [IP_W-1:0]          hop_reg;
    logic [IP_W-1:0]          hop_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;

    logic                     wr_en;
    logic [ENTRY_W-1:0]       wr_addr;
    route_entry_t             wr_entry;
    logic                     rd_en;
    logic [ENTRY_BITS-1:0]    rd_data;
    route_entry_t             rd_entry;
    logic                     pend_valid;
    sel_ctrl_t                sel_ctrl;
    best_route_t              best;
    logic                     accept;

    assign accept     = start && !busy;
    assign rd_entry   = route_entry_t'(rd_data);
    assign pend_valid = valid_reg[pend_idx_reg];

    // Entry memory.
    lprt_ram #(
        .DATA_W (ENTRY_BITS),
        .DEPTH  (ROUTE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    // Lookup candidate tracker.
    assign sel_ctrl.clear = accept;
    assign sel_ctrl.check = pend_reg && (op_reg == OP_LOOKUP);
    assign sel_ctrl.valid = pend_valid;

    lprt_select u_select (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sel_ctrl),
        .ip    (ip_reg),
        .entry (rd_entry),
        .best  (best)
    );

    // Sequencer, memory write-back and result formation.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = (state_reg == S_SCAN);
        pend_idx_next = cnt_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        hop_out_next  = hop_out_reg;
        direct_next   = direct_reg;
        op_next       = op_reg;
        ip_next       = ip_reg;
        mask_next     = mask_reg;
        hop_next      = hop_reg;
        pos_next      = pos_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg;
        wr_entry      = rd_entry;
        rd_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = opcode;
                    ip_next      = ip_addr;
                    mask_next    = mask;
                    hop_next     = next_hop;
                    pos_next     = position;
                    cnt_next     = '0;
                    status_next  = ST_OK;
                    hop_out_next = '0;
                    direct_next  = 1'b0;
                    case (opcode)
                        OP_ADD:
                        begin
                            if (count_reg == COUNT_W'(ROUTE_ENTRIES))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (CMP_W'(position) >= CMP_W'(count_reg))
                            begin
                                status_next = ST_BAD_POS;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                // A free slot exists whenever the table is not full.
                if (!valid_reg[cnt_reg])
                begin
                    wr_en           = 1'b1;
                    wr_addr         = cnt_reg;
                    wr_entry.mask   = mask_reg;
                    wr_entry.prefix = ip_reg;
                    wr_entry.hop    = hop_reg;
                    wr_entry.rank   = ENTRY_W'(count_reg);
                    valid_next[cnt_reg] = 1'b1;
                    count_next      = count_reg + 1'b1;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SCAN:
            begin
                rd_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_TAIL:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg == OP_REMOVE)
                begin
                    count_next = count_reg - 1'b1;
                end
                else if (!best.found)
                begin
                    status_next = ST_NO_ROUTE;
                end
                else if (best.hop == '0)
                begin
                    hop_out_next = ip_reg;
                    direct_next  = 1'b1;
                end
                else
                begin
                    hop_out_next = best.hop;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Remove sweep: drop the entry at the position, close the rank gap.
        if (pend_reg && (op_reg == OP_REMOVE) && pend_valid)
        begin
            if (CMP_W'(rd_entry.rank) == CMP_W'(pos_reg))
            begin
                valid_next[pend_idx_reg] = 1'b0;
            end
            else if (CMP_W'(rd_entry.rank) > CMP_W'(pos_reg))
            begin
                wr_en         = 1'b1;
                wr_addr       = pend_idx_reg;
                wr_entry      = rd_entry;
                wr_entry.rank = rd_entry.rank - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            op_reg    <= OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            op_reg    <= op_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        hop_out_reg  <= hop_out_next;
        direct_reg   <= direct_next;
        ip_reg       <= ip_next;
        mask_reg     <= mask_next;
        hop_reg      <= hop_next;
        pos_reg      <= pos_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign hop_out     = hop_out_reg;
    assign direct      = direct_reg;
    assign entry_count = COUNT_OUT_W'(count_reg);

`ifndef SYNTHESIS
    // A result is only shown once the operation has ended.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // Every accepted operation either runs or answers at once.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (busy || done))
        else $error("accepted operation lost");

    // Between operations the count matches the valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> ($countones(valid_reg) == int'(count_reg)))
        else $error("entry count out of step with valid bits");

    // A full report only comes with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count_reg == COUNT_W'(ROUTE_ENTRIES)))
        else $error("full reported on a table with room");
`endif

endmodule

/* tb/sv/tb_longest_prefix_route_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-prefix route table testbench
// Drives add, remove, lookup and unused-opcode commands through the start/busy handshake.
// Every result is checked against a route-table predictor held in the bench or a pinned value.
// A short table of directed commands comes first. Random phases follow that
// fill the table, mix all operations, and drain it again. The sender works in
// bursts with random gaps between them.
// ----------------------------------------------------------------------------
module tb_longest_prefix_route_table;
    import lprt_pkg::*;

    localparam int          TARGET_ITEMS = 1950;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    // One command and one result, at the widths of the block.
    typedef struct packed {
        logic [1:0]      op;
        logic [IP_W-1:0] ip;
        logic [IP_W-1:0] msk;
        logic [IP_W-1:0] hop;
        logic [POS_W-1:0] pos;
    } route_cmd_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [IP_W-1:0]        hop_out;
        logic                   direct;
        logic [COUNT_OUT_W-1:0] count;
    } route_result_t;

    // A directed command, with the result pinned where it is obvious.
    typedef struct packed {
        route_cmd_t    cmd;
        logic          pinned;
        route_result_t want;
    } probe_row_t;

    typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} stim_phase_t;

    localparam int N_ROWS = 21;
    localparam probe_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{'{OP_LOOKUP, 32'hC0A8_0001, 32'h0, 32'h0, 4'd0}, 1'b1,
          '{ST_NO_ROUTE, 32'h0, 1'b0, 5'd0}},
        '{'{OP_REMOVE, 32'h0, 32'h0, 32'h0, 4'd0}, 1'b1,
          '{ST_BAD_POS, 32'h0, 1'b0, 5'd0}},
        '{'{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd0}},
        '{'{OP_ADD, 32'h0, 32'h0, 32'h0A00_0001, 4'd0}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd1}},
        '{'{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'd0}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd2}},
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0}, 1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 1'b1, 5'd2}},
        '{'{OP_LOOKUP, 32'h0, 32'h0, 32'h0, 4'd0}, 1'b1,
          '{ST_OK, 32'h0A00_0001, 1'b0, 5'd2}},
        '{'{OP_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 4'd0}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd3}},
        '{'{OP_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_00FE, 4'd0}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd4}},
        '{'{OP_LOOKUP, 32'hC0A8_1234, 32'h0, 32'h0, 4'd0}, 1'b0, '0},
        '{'{OP_ADD, 32'hC0A8_0101, 32'hFFFF_0000, 32'h1111_1111, 4'd0}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd5}},
        '{'{OP_LOOKUP, 32'hC0A8_0101, 32'h0, 32'h0, 4'd0}, 1'b0, '0},
        '{'{OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0, 4'd0}, 1'b1,
          '{ST_OK, 32'h0, 1'b0, 5'd6}},
        '{'{OP_LOOKUP, 32'hC0A8_01FF, 32'h0, 32'h0, 4'd0}, 1'b0, '0},
        '{'{OP_REMOVE, 32'h0, 32'h0, 32'h0, 4'd0}, 1'b0, '0},
        '{'{OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 4'd0}, 1'b0, '0},
        '{'{OP_REMOVE, 32'h0, 32'h0, 32'h0, 4'd4}, 1'b0, '0},
        '{'{OP_REMOVE, 32'h0, 32'h0, 32'h0, 4'hF}, 1'b1,
          '{ST_BAD_POS, 32'h0, 1'b0, 5'd4}},
        '{'{OP_LOOKUP, 32'hC0A8_01FF, 32'h0, 32'h0, 4'd0}, 1'b0, '0},
        '{'{OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0}, 1'b0, '0},
        '{'{OP_LOOKUP, 32'h0, 32'h0, 32'h0, 4'd0}, 1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic [1:0]             opcode;
    logic [IP_W-1:0]        ip_addr;
    logic [IP_W-1:0]        mask;
    logic [IP_W-1:0]        next_hop;
    logic [POS_W-1:0]       position;
    logic                   busy;
    logic                   done;
    logic [1:0]             status;
    logic [IP_W-1:0]        hop_out;
    logic                   direct;
    logic [COUNT_OUT_W-1:0] entry_count;

    longest_prefix_route_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .ip_addr     (ip_addr),
        .mask        (mask),
        .next_hop    (next_hop),
        .position    (position),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .hop_out     (hop_out),
        .direct      (direct),
        .entry_count (entry_count)
    );

    // Predicted table contents, updated at each accepted transfer.
    logic            route_valid [ROUTE_ENTRIES];
    logic [IP_W-1:0] route_mask  [ROUTE_ENTRIES];
    logic [IP_W-1:0] route_prefix[ROUTE_ENTRIES];
    logic [IP_W-1:0] route_hop   [ROUTE_ENTRIES];
    int              route_age   [ROUTE_ENTRIES];
    int              route_count;

    // Results still owed by the block, oldest first.
    route_result_t   awaited_results[$];

    // Pinned result for the command being offered, if any.
    logic            pin_en;
    route_result_t   pin_value;

    logic            busy_at_fall;
    int              error_count;
    int              items_sent;
    int              burst_left;
    int              n_add, n_full, n_remove, n_bad_pos, n_lookup, n_direct, n_no_route;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("longest_prefix_route_table verification failed");
        $finish;
    end

    // Applies one command to the predicted table and returns its result.
    function automatic route_result_t predict_route(route_cmd_t c);
        route_result_t r;
        int            best;
        logic          found;
        r      = '0;
        found  = 1'b0;
        best   = 0;
        case (c.op)
            OP_ADD:
            begin
                r.status = ST_FULL;
                for (int i = 0; i < ROUTE_ENTRIES; i++)
                begin
                    if (!route_valid[i] && r.status == ST_FULL)
                    begin
                        route_valid[i]  = 1'b1;
                        route_mask[i]   = c.msk;
                        route_prefix[i] = c.ip;
                        route_hop[i]    = c.hop;
                        route_age[i]    = route_count;
                        route_count++;
                        r.status = ST_OK;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (int'(c.pos) >= route_count)
                begin
                    r.status = ST_BAD_POS;
                end
                else
                begin
                    // Drop the entry at that age and close the gap behind it.
                    for (int i = 0; i < ROUTE_ENTRIES; i++)
                    begin
                        if (route_valid[i] && route_age[i] == int'(c.pos))
                            route_valid[i] = 1'b0;
                    end
                    for (int i = 0; i < ROUTE_ENTRIES; i++)
                    begin
                        if (route_valid[i] && route_age[i] > int'(c.pos))
                            route_age[i]--;
                    end
                    route_count--;
                end
            end
            OP_LOOKUP:
            begin
                // Largest mask wins; the youngest entry wins a tie.
                for (int i = 0; i < ROUTE_ENTRIES; i++)
                begin
                    if (route_valid[i] && (route_mask[i] & c.ip) == route_prefix[i])
                    begin
                        if (!found || route_mask[i] > route_mask[best] ||
                            (route_mask[i] == route_mask[best] &&
                             route_age[i] > route_age[best]))
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                begin
                    r.status = ST_NO_ROUTE;
                end
                else if (route_hop[best] == '0)
                begin
                    r.hop_out = c.ip;
                    r.direct  = 1'b1;
                end
                else
                begin
                    r.hop_out = route_hop[best];
                end
            end
            default:
            begin
                r.status = ST_OK;
            end
        endcase
        r.count = COUNT_OUT_W'(route_count);
        return r;
    endfunction

    // Contiguous mask with the given prefix length.
    function automatic logic [IP_W-1:0] prefix_mask(int len);
        if (len == 0)
            return '0;
        return ~32'h0 << (32 - len);
    endfunction

    // Builds a random command suited to the phase, with most lookups aimed at
    // stored routes and most adds drawn from a few shared address blocks.
    function automatic route_cmd_t pick_cmd(stim_phase_t ph);
        route_cmd_t      c;
        int              roll;
        int              slot;
        int              len;
        logic [IP_W-1:0] base;
        c.ip  = $urandom;
        c.msk = $urandom;
        c.hop = $urandom;
        c.pos = POS_W'($urandom_range(0, 15));
        roll  = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  c.op = (roll < 85) ? OP_ADD : OP_LOOKUP;
            PH_DRAIN: c.op = (roll < 80) ? OP_REMOVE : OP_LOOKUP;
            default:
            begin
                if (roll < 45)
                    c.op = OP_LOOKUP;
                else if (roll < 70)
                    c.op = OP_ADD;
                else if (roll < 95)
                    c.op = OP_REMOVE;
                else
                    c.op = OP_UNUSED;
            end
        endcase
        roll = $urandom_range(0, 99);
        case (c.op)
            OP_ADD:
            begin
                case ($urandom_range(0, 3))
                    0:       base = 32'h0A00_0000;
                    1:       base = 32'hC0A8_0000;
                    2:       base = 32'hAC10_0000;
                    default: base = $urandom;
                endcase
                base = base | ($urandom & 32'h0000_FFFF);
                if (roll < 40)
                    len = 8 * $urandom_range(0, 4);
                else
                    len = $urandom_range(0, 32);
                // A few masks are arbitrary bit patterns.
                if (roll >= 90)
                    c.msk = $urandom;
                else
                    c.msk = prefix_mask(len);
                // Some prefixes keep bits outside the mask and can never match.
                c.ip  = ($urandom_range(0, 99) < 80) ? (base & c.msk) : base;
                c.hop = ($urandom_range(0, 99) < 20) ? '0 : IP_W'($urandom);
            end
            OP_REMOVE:
            begin
                if (route_count > 0 && roll < 90)
                    c.pos = POS_W'($urandom_range(0, route_count - 1));
            end
            OP_LOOKUP:
            begin
                if (route_count > 0 && roll < 70)
                begin
                    slot = $urandom_range(0, ROUTE_ENTRIES - 1);
                    while (!route_valid[slot])
                        slot = $urandom_range(0, ROUTE_ENTRIES - 1);
                    c.ip = (route_prefix[slot] & route_mask[slot]) |
                           ($urandom & ~route_mask[slot]);
                end
                else if (roll < 75)
                begin
                    c.ip = '0;
                end
                else if (roll < 80)
                begin
                    c.ip = '1;
                end
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    // Offers one command, waits for the transfer, then plays out the burst.
    task automatic issue_cmd(route_cmd_t c, logic pinned, route_result_t want);
        int gap;
        start     <= 1'b1;
        opcode    <= c.op;
        ip_addr   <= c.ip;
        mask      <= c.msk;
        next_hop  <= c.hop;
        position  <= c.pos;
        pin_en    = pinned;
        pin_value = want;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        if (c.op != OP_UNUSED)
            items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // The block's busy is stable at the falling edge; sample it there.
    always @(negedge clk)
    begin
        busy_at_fall <= busy;
    end

    // Result checking and prediction at each rising edge.
    always @(posedge clk)
    begin
        route_result_t got;
        route_result_t want;
        route_cmd_t    c;
        if (rst_n)
        begin
            // Check a returned result against the oldest expectation.
            if (done)
            begin
                got = '{status, hop_out, direct, entry_count};
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with none expected, status %0d hop %h",
                             $time, got.status, got.hop_out);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                        error_count++;
                    if (got.status !== want.status)
                        $display("%0t ns: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    if (got.hop_out !== want.hop_out)
                        $display("%0t ns: hop_out expected %h, actual %h",
                                 $time, want.hop_out, got.hop_out);
                    if (got.direct !== want.direct)
                        $display("%0t ns: direct expected %0d, actual %0d",
                                 $time, want.direct, got.direct);
                    if (got.count !== want.count)
                        $display("%0t ns: entry_count expected %0d, actual %0d",
                                 $time, want.count, got.count);
                end
            end
            // Predict the result of a command taken at this edge.
            if (start && !busy_at_fall)
            begin
                c    = '{opcode, ip_addr, mask, next_hop, position};
                want = predict_route(c);
                case (c.op)
                    OP_ADD:
                    begin
                        n_add++;
                        if (want.status == ST_FULL)
                            n_full++;
                    end
                    OP_REMOVE:
                    begin
                        n_remove++;
                        if (want.status == ST_BAD_POS)
                            n_bad_pos++;
                    end
                    OP_LOOKUP:
                    begin
                        n_lookup++;
                        if (want.direct)
                            n_direct++;
                        if (want.status == ST_NO_ROUTE)
                            n_no_route++;
                    end
                    default:
                    begin
                    end
                endcase
                if (pin_en)
                    want = pin_value;
                awaited_results.push_back(want);
            end
        end
    end

    // Stimulus: reset, directed table, random phases, end of run.
    initial
    begin : stimulus
        stim_phase_t ph;
        route_cmd_t  c;
        int          round;
        int          n;
        int          full_tries;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_ADD;
        ip_addr      = '0;
        mask         = '0;
        next_hop     = '0;
        position     = '0;
        pin_en       = 1'b0;
        pin_value    = '0;
        busy_at_fall = 1'b1;
        error_count  = 0;
        items_sent   = 0;
        burst_left   = 8;
        n_add = 0; n_full = 0; n_remove = 0; n_bad_pos = 0;
        n_lookup = 0; n_direct = 0; n_no_route = 0;
        for (int i = 0; i < ROUTE_ENTRIES; i++)
        begin
            route_valid[i]  = 1'b0;
            route_mask[i]   = '0;
            route_prefix[i] = '0;
            route_hop[i]    = '0;
            route_age[i]    = 0;
        end
        route_count = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands.
        for (int i = 0; i < N_ROWS; i++)
            issue_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
        drain_results();

        // Random phases: fill to full, mixed traffic, drain to empty, mixed.
        round = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (round > 0 && $urandom_range(0, 1) == 1)
                drain_results();
            case (round % 4)
                0:       ph = PH_FILL;
                2:       ph = PH_DRAIN;
                default: ph = PH_MIXED;
            endcase
            case (ph)
                PH_FILL:
                begin
                    full_tries = 0;
                    while (full_tries < 3)
                    begin
                        c = pick_cmd(PH_FILL);
                        if (c.op == OP_ADD && route_count >= ROUTE_ENTRIES)
                            full_tries++;
                        issue_cmd(c, 1'b0, '0);
                    end
                end
                PH_DRAIN:
                begin
                    while (route_count > 0)
                        issue_cmd(pick_cmd(PH_DRAIN), 1'b0, '0);
                    repeat (2)
                        issue_cmd(pick_cmd(PH_DRAIN), 1'b0, '0);
                end
                default:
                begin
                    n = $urandom_range(60, 160);
                    repeat (n)
                        issue_cmd(pick_cmd(PH_MIXED), 1'b0, '0);
                end
            endcase
            round++;
        end

        // Let every owed result arrive, then watch for stray strobes.
        drain_results();
        repeat (ROUTE_ENTRIES + 8) @(negedge clk);

        $display("Covered %0d commands in %0d phases: %0d adds (%0d to a full table),",
                 items_sent, round, n_add, n_full);
        $display("%0d removes (%0d bad position), %0d lookups (%0d direct, %0d no route).",
                 n_remove, n_bad_pos, n_lookup, n_direct, n_no_route);
        if (error_count == 0)
            $display("longest_prefix_route_table verification clean");
        else
            $display("longest_prefix_route_table verification failed");
        $finish;
    end

endmodule
